// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst_n is high.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising edge of clk while rst_n is high.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/utcn_pkg.sv =====
// Types and constants of the usage threshold crossing notifier.
`timescale 1ns / 1ps

package utcn_pkg;

    localparam int THRESH_DEPTH_DEFAULT = 16;
    localparam int VALUE_W = 64;
    localparam int EVENT_W = 8;
    localparam int COUNT_W = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_USAGE = 1'b1;

    localparam logic REG_MEM_COUNT = 1'b0;
    localparam logic REG_MEMSW_COUNT = 1'b1;

    typedef struct packed {
        logic               mode;
        logic               table_select;
        logic [3:0]         entry_index;
        logic [VALUE_W-1:0] threshold_value;
        logic [EVENT_W-1:0] event_id;
        logic [VALUE_W-1:0] usage;
    } cmd_t;

    typedef struct packed {
        logic [EVENT_W-1:0] signal_event;
        logic               signal_bank;
        logic               crossed_upward;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [VALUE_W-1:0] threshold;
        logic [EVENT_W-1:0] event_id;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DOWN,
        ST_UP,
        ST_DONE
    } state_t;

endpackage

// ===== design/utcn_table.sv =====
// Threshold and event id storage for both banks, one write and one registered read port.
`timescale 1ns / 1ps

module utcn_table
    import utcn_pkg::*;
#(
    parameter int THRESH_DEPTH = THRESH_DEPTH_DEFAULT,
    localparam int IDX_W = (THRESH_DEPTH > 1) ? $clog2(THRESH_DEPTH) : 1,
    localparam int ADDR_W = IDX_W + 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    entry_t mem [2**ADDR_W];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/usage_threshold_crossing_notifier.sv =====
// Top level of the usage threshold crossing notifier: sequencer, compare unit and registers.
//
// Usage: a command word is taken on start while busy is low. A load word (mode 0)
// writes one threshold and event id into the selected bank in that same edge and
// leaves busy low. A usage word (mode 1) raises busy while a sequencer walks the
// bank through one shared 64-bit comparator, one stored threshold per cycle: first
// downward from the stored position, then upward. Each crossed threshold yields one
// result word, shown for one cycle with result_valid high; the last word of the walk
// carries last. The receiver cannot stall, so words are never held back.
// Each usage word compares every crossed entry plus at most two entries that cross
// nothing. The single memory read port, one entry per cycle, sets the walk's pace.
// A result word waits in a pending register until the next crossing or the done
// state, then passes through the result register; the last one appears in the
// first cycle after busy falls. An empty bank gives no word; its walk ends in prep.
// Reset clears the sequencer, both counts and both positions to minus one; the
// threshold memory is not cleared and must be loaded before it is used.
// Counts are written over the APB port at byte addresses 0 and 4; the user must do so
// only while the block is idle, as the block itself does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module usage_threshold_crossing_notifier
    import utcn_pkg::*;
#(
    parameter int THRESH_DEPTH = THRESH_DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cmd_t               cmd,
    output logic               result_valid,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IDX_W = (THRESH_DEPTH > 1) ? $clog2(THRESH_DEPTH) : 1;
    localparam int ADDR_W = IDX_W + 1;
    localparam int CNT_W = $clog2(THRESH_DEPTH + 1);
    localparam int POS_W = CNT_W + 1;

    state_t state_reg;
    state_t state_next;

    logic [COUNT_W-1:0] mem_count_reg;
    logic [COUNT_W-1:0] memsw_count_reg;
    logic               cfg_write;
    logic [COUNT_W-1:0] cfg_sel;

    logic               bank_reg;
    logic [VALUE_W-1:0] usage_reg;

    logic signed [POS_W-1:0] pos_reg [2];
    logic signed [POS_W-1:0] cur_reg;
    logic signed [POS_W-1:0] cur_next;
    logic signed [POS_W-1:0] cur_dec;
    logic signed [POS_W-1:0] cur_inc;
    logic signed [POS_W-1:0] rd_idx;
    logic signed [POS_W-1:0] pos_start;
    logic signed [POS_W-1:0] cnt_s;
    logic [7:0]              cfg_sel8;
    logic [CNT_W-1:0]        cnt_sel;
    logic                    cnt_zero;
    logic                    at_top;
    logic                    thr_above;
    logic                    pos_we;

    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [EVENT_W-1:0] pend_event_reg;
    logic [EVENT_W-1:0] pend_event_next;
    logic               pend_up_reg;
    logic               pend_up_next;
    logic               emit;
    logic               emit_last;

    logic    res_valid_reg;
    result_t res_reg;

    logic              accept;
    logic              load_we;
    logic [IDX_W+3:0]  widx_ext;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    entry_t            wdata;
    entry_t            rd_data;

    assign accept = start && !busy;
    assign busy = (state_reg != ST_IDLE);

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg_sel = (paddr[2] == REG_MEMSW_COUNT) ? memsw_count_reg : mem_count_reg;
    assign prdata = {{(PDATA_W - COUNT_W){1'b0}}, cfg_sel};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_count_reg <= '0;
            memsw_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_MEM_COUNT:   mem_count_reg <= pwdata[COUNT_W-1:0];
                REG_MEMSW_COUNT: memsw_count_reg <= pwdata[COUNT_W-1:0];
                default:         mem_count_reg <= mem_count_reg;
            endcase
        end
    end

    assign widx_ext = {{IDX_W{1'b0}}, cmd.entry_index};
    assign load_we = accept && (cmd.mode == MODE_LOAD)
                     && ({4'b0, cmd.entry_index} < 8'(THRESH_DEPTH));
    assign waddr = {cmd.table_select, widx_ext[IDX_W-1:0]};
    assign wdata = '{threshold: cmd.threshold_value, event_id: cmd.event_id};
    assign raddr = {bank_reg, rd_idx[IDX_W-1:0]};

    utcn_table #(
        .THRESH_DEPTH(THRESH_DEPTH)
    ) u_table (
        .clk(clk),
        .we(load_we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bank_reg <= cmd.table_select;
            usage_reg <= cmd.usage;
        end
    end

    assign cfg_sel8 = {3'b0, bank_reg ? memsw_count_reg : mem_count_reg};
    assign cnt_sel = (cfg_sel8 > 8'(THRESH_DEPTH)) ? CNT_W'(THRESH_DEPTH)
                                                    : cfg_sel8[CNT_W-1:0];
    assign cnt_s = signed'({1'b0, cnt_sel});
    assign cnt_zero = (cnt_sel == '0);
    assign pos_start = (pos_reg[bank_reg] >= cnt_s) ? (cnt_s - POS_W'(1))
                                                     : pos_reg[bank_reg];
    assign cur_dec = cur_reg - POS_W'(1);
    assign cur_inc = cur_reg + POS_W'(1);
    assign at_top = (cur_inc >= cnt_s);
    assign thr_above = (rd_data.threshold > usage_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.mode == MODE_USAGE))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (cnt_zero)
                begin
                    state_next = ST_IDLE;
                end
                else if (!pos_start[POS_W-1])
                begin
                    state_next = ST_DOWN;
                end
                else
                begin
                    state_next = ST_UP;
                end
            end
            ST_DOWN:
            begin
                if (thr_above)
                begin
                    state_next = (cur_reg == '0) ? ST_UP : ST_DOWN;
                end
                else
                begin
                    state_next = at_top ? ST_DONE : ST_UP;
                end
            end
            ST_UP:
            begin
                if (!thr_above && !at_top)
                begin
                    state_next = ST_UP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next = cur_reg;
        rd_idx = cur_reg;
        pend_valid_next = pend_valid_reg;
        pend_event_next = pend_event_reg;
        pend_up_next = pend_up_reg;
        emit = 1'b0;
        emit_last = 1'b0;
        pos_we = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_idx = cur_reg;
            end
            ST_PREP:
            begin
                pend_valid_next = 1'b0;
                cur_next = pos_start[POS_W-1] ? '0 : pos_start;
                rd_idx = cur_next;
            end
            ST_DOWN:
            begin
                if (thr_above)
                begin
                    emit = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_event_next = rd_data.event_id;
                    pend_up_next = 1'b0;
                    cur_next = (cur_reg == '0) ? '0 : cur_dec;
                end
                else
                begin
                    cur_next = cur_inc;
                end
                rd_idx = cur_next;
            end
            ST_UP:
            begin
                if (!thr_above)
                begin
                    emit = pend_valid_reg;
                    pend_valid_next = 1'b1;
                    pend_event_next = rd_data.event_id;
                    pend_up_next = 1'b1;
                    cur_next = cur_inc;
                end
                rd_idx = cur_next;
            end
            ST_DONE:
            begin
                emit = pend_valid_reg;
                emit_last = 1'b1;
                pend_valid_next = 1'b0;
                pos_we = 1'b1;
            end
            default:
            begin
                rd_idx = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg[0] <= '1;
            pos_reg[1] <= '1;
        end
        else
        begin
            state_reg <= state_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg <= emit;
            if (pos_we)
            begin
                pos_reg[bank_reg] <= cur_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        pend_event_reg <= pend_event_next;
        pend_up_reg <= pend_up_next;
        res_reg <= '{signal_event: pend_event_reg, signal_bank: bank_reg,
                     crossed_upward: pend_up_reg, last: emit_last};
    end

    assign result_valid = res_valid_reg;
    assign result = res_reg;

    `ASSERT_ALWAYS(a_mid_result_busy, (result_valid && !result.last) |-> busy,
                   "A result word that is not the last one appeared outside a walk.")
    `ASSERT_ALWAYS(a_usage_starts_walk,
                   (accept && cmd.mode == MODE_USAGE) |=> (state_reg == ST_PREP),
                   "An accepted usage word did not start a walk.")
    `ASSERT_ALWAYS(a_done_returns_idle, (state_reg == ST_DONE) |=> (state_reg == ST_IDLE),
                   "The walk did not end one cycle after its final step.")
    `ASSERT_ALWAYS(a_cur_in_range,
                   (state_reg == ST_DOWN || state_reg == ST_UP)
                   |-> (!cur_reg[POS_W-1] && (cur_reg < cnt_s)),
                   "The walk index left the range of entries in use.")
    `ASSERT_NEVER(a_load_while_busy, load_we && busy,
                  "A table entry was written during a walk.")

endmodule

// ===== tb/utcn_checker.sv =====
// Checker for the usage threshold crossing notifier: tracks tables and counts, predicts and compares signal words.
`timescale 1ns / 1ps

module utcn_checker
    import utcn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  cmd_t               cmd,
    input  logic               result_valid,
    input  result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 fail_count,
    output int                 pending
);

    localparam int DEPTH = THRESH_DEPTH_DEFAULT;

    logic [VALUE_W-1:0] thr_mem [2][DEPTH];
    logic [EVENT_W-1:0] evt_mem [2][DEPTH];
    int                 level_pos [2];
    int                 mem_cnt;
    int                 memsw_cnt;
    int                 fails;
    result_t            crossings_q [$];

    task automatic predict_crossings(input logic b, input logic [VALUE_W-1:0] level);
        int      lim;
        int      pos;
        result_t r;
        result_t walk [$];
        lim = b ? memsw_cnt : mem_cnt;
        if (lim > DEPTH)
        begin
            lim = DEPTH;
        end
        if (lim == 0)
        begin
            return;
        end
        pos = level_pos[b];
        if (pos >= lim)
        begin
            pos = lim - 1;
        end
        while (pos >= 0 && thr_mem[b][pos] > level)
        begin
            r.signal_event   = evt_mem[b][pos];
            r.signal_bank    = b;
            r.crossed_upward = 1'b0;
            r.last           = 1'b0;
            walk.push_back(r);
            pos--;
        end
        pos++;
        while (pos < lim && thr_mem[b][pos] <= level)
        begin
            r.signal_event   = evt_mem[b][pos];
            r.signal_bank    = b;
            r.crossed_upward = 1'b1;
            r.last           = 1'b0;
            walk.push_back(r);
            pos++;
        end
        level_pos[b] = pos - 1;
        if (walk.size() > 0)
        begin
            r = walk.pop_back();
            r.last = 1'b1;
            walk.push_back(r);
        end
        foreach (walk[i])
        begin
            crossings_q.push_back(walk[i]);
        end
    endtask

    task automatic compare_signal(input result_t got);
        result_t want;
        if (crossings_q.size() == 0)
        begin
            $error("unexpected signal word: event %0d bank %0d upward %0d last %0d",
                   got.signal_event, got.signal_bank, got.crossed_upward, got.last);
            fails++;
            return;
        end
        want = crossings_q.pop_front();
        if (got.signal_event !== want.signal_event)
        begin
            $error("signal_event: expected %0d, got %0d", want.signal_event, got.signal_event);
            fails++;
        end
        if (got.signal_bank !== want.signal_bank)
        begin
            $error("signal_bank: expected %0d, got %0d", want.signal_bank, got.signal_bank);
            fails++;
        end
        if (got.crossed_upward !== want.crossed_upward)
        begin
            $error("crossed_upward: expected %0d, got %0d",
                   want.crossed_upward, got.crossed_upward);
            fails++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fails++;
        end
    endtask

    initial
    begin
        fails = 0;
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_pos[0] = -1;
            level_pos[1] = -1;
            mem_cnt = 0;
            memsw_cnt = 0;
            crossings_q.delete();
        end
        else
        begin
            if (result_valid)
            begin
                compare_signal(result);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_MEMSW_COUNT)
                begin
                    memsw_cnt = int'(pwdata[COUNT_W-1:0]);
                end
                else
                begin
                    mem_cnt = int'(pwdata[COUNT_W-1:0]);
                end
            end
            if (start && !busy)
            begin
                if (cmd.mode == MODE_LOAD)
                begin
                    thr_mem[cmd.table_select][cmd.entry_index] = cmd.threshold_value;
                    evt_mem[cmd.table_select][cmd.entry_index] = cmd.event_id;
                end
                else
                begin
                    predict_crossings(cmd.table_select, cmd.usage);
                end
            end
        end
        pending <= crossings_q.size();
        fail_count <= fails;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the usage threshold crossing notifier testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
    import utcn_pkg::*;
();

    localparam int   DEPTH        = THRESH_DEPTH_DEFAULT;
    localparam int   DRAIN_CYCLES = 24;
    localparam int   STALL_LIMIT  = 2000;
    localparam int   WORD_TARGET  = 230;
    localparam logic BANK_MEM     = 1'b0;
    localparam logic BANK_MEMSW   = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    cmd_t               cmd;
    logic               result_valid;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    int                 burst_left;
    int                 sent_words;
    logic [VALUE_W-1:0] table_shadow [2][DEPTH];

    usage_threshold_crossing_notifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    utcn_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (psel && penable && pwrite && pready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_word(input cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        burst_left--;
        sent_words++;
    endtask

    task automatic load_word(input logic b, input logic [3:0] idx,
                             input logic [VALUE_W-1:0] level, input logic [EVENT_W-1:0] ev);
        cmd_t c;
        c.mode            = MODE_LOAD;
        c.table_select    = b;
        c.entry_index     = idx;
        c.threshold_value = level;
        c.event_id        = ev;
        c.usage           = {$urandom, $urandom};
        table_shadow[b][idx] = level;
        send_word(c);
    endtask

    task automatic usage_word(input logic b, input logic [VALUE_W-1:0] level);
        cmd_t c;
        c.mode            = MODE_USAGE;
        c.table_select    = b;
        c.entry_index     = 4'($urandom_range(0, 15));
        c.threshold_value = {$urandom, $urandom};
        c.event_id        = 8'($urandom);
        c.usage           = level;
        send_word(c);
    endtask

    task automatic quiesce();
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input logic reg_idx, input logic [COUNT_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= {{(PDATA_W-COUNT_W){1'b0}}, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reload_bank(input logic b);
        int                 shape;
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] level;
        shape = $urandom_range(0, 5);
        case (shape)
            1:       mask = 64'h0000_0000_000F_FFFF;
            2, 3:    mask = 64'h07FF_FFFF_FFFF_FFFF;
            default: mask = 64'h0000_0000_0000_000F;
        endcase
        level = (shape == 4) ? 64'hFFFF_FFFF_FFFF_FF00 : ({$urandom, $urandom} & mask);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (shape == 5)
            begin
                level = {$urandom, $urandom};
            end
            else if (i > 0)
            begin
                level = level + ({$urandom, $urandom} & mask);
            end
            load_word(b, 4'(i), level, 8'($urandom));
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_usage(input logic b);
        int k;
        k = $urandom_range(0, DEPTH - 1);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return {$urandom, $urandom};
            3, 4, 5: return table_shadow[b][k];
            6, 7:    return table_shadow[b][k] - 1;
            default: return table_shadow[b][k] + 1;
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return COUNT_W'($urandom_range(DEPTH + 1, 31));
            2, 3, 4:    return COUNT_W'($urandom_range(1, DEPTH - 1));
            default:    return COUNT_W'(DEPTH);
        endcase
    endfunction

    initial
    begin
        int   phase;
        logic b;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        idle_cycles <= 0;
        burst_left = 0;
        sent_words = 0;
        phase = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both banks start empty, so usage words must not signal anything.
        usage_word(BANK_MEM, '1);
        usage_word(BANK_MEMSW, '0);
        load_word(BANK_MEM, 4'd0, 64'h0000_0000_0000_0000, 8'h00);
        load_word(BANK_MEM, 4'd1, 64'h0000_0000_0000_0010, 8'hA5);
        load_word(BANK_MEM, 4'd2, 64'h8000_0000_0000_0000, 8'h5A);
        load_word(BANK_MEM, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
        // The second bank is deliberately out of order.
        load_word(BANK_MEMSW, 4'd0, 64'h300, 8'h01);
        load_word(BANK_MEMSW, 4'd1, 64'h100, 8'h02);
        load_word(BANK_MEMSW, 4'd2, 64'h200, 8'h03);
        load_word(BANK_MEMSW, 4'd3, 64'h050, 8'h04);
        quiesce();
        write_count(REG_MEM_COUNT, 5'd4);
        write_count(REG_MEMSW_COUNT, 5'd4);
        usage_word(BANK_MEM, '1);
        usage_word(BANK_MEM, '0);
        usage_word(BANK_MEM, 64'h7FFF_FFFF_FFFF_FFFF);
        usage_word(BANK_MEM, 64'h10);
        usage_word(BANK_MEMSW, 64'h250);
        usage_word(BANK_MEMSW, 64'h300);
        usage_word(BANK_MEMSW, 64'h150);
        usage_word(BANK_MEMSW, 64'h10);
        usage_word(BANK_MEM, '1);
        // Shrinking the count leaves the stored position beyond the table.
        quiesce();
        write_count(REG_MEM_COUNT, 5'd2);
        usage_word(BANK_MEM, '0);

        while (sent_words < WORD_TARGET)
        begin
            if (phase == 0)
            begin
                reload_bank(BANK_MEM);
                reload_bank(BANK_MEMSW);
            end
            else
            begin
                reload_bank(1'($urandom_range(0, 1)));
            end
            quiesce();
            write_count(REG_MEM_COUNT, (phase == 0) ? 5'd31 : pick_count());
            write_count(REG_MEMSW_COUNT, (phase == 0) ? 5'd16 : pick_count());
            repeat ($urandom_range(20, 30))
            begin
                b = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0)
                begin
                    load_word(b, 4'($urandom_range(0, 15)), {$urandom, $urandom}, 8'($urandom));
                end
                else
                begin
                    usage_word(b, pick_usage(b));
                end
            end
            phase++;
        end
        quiesce();

        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/utcn_pkg.sv
design/utcn_table.sv
design/usage_threshold_crossing_notifier.sv
tb/utcn_checker.sv
tb/tb_top.sv
